>>> rtl/tkst_pkg.sv
package tkst_pkg;

  // Default table size and name length in bytes.
  localparam int unsigned DefaultDepth     = 10;
  localparam int unsigned DefaultNameChars = 8;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned NameW  = 64;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DUMP   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the broadcast entry in order
    logic rot;  // rotate the chain by one cell toward the top
  } cell_ctl_t;

endpackage

>>> rtl/tkst_cell.sv
module tkst_cell (
  input  logic                                 clk,
  input  tkst_pkg::cell_ctl_t                  ctl,
  input  logic                                 valid,
  input  logic signed [tkst_pkg::ScoreW-1:0]   new_score,
  input  logic        [tkst_pkg::NameW-1:0]    new_name,
  input  logic                                 prev_cmp,
  input  logic signed [tkst_pkg::ScoreW-1:0]   up_score,
  input  logic        [tkst_pkg::NameW-1:0]    up_name,
  input  logic signed [tkst_pkg::ScoreW-1:0]   dn_score,
  input  logic        [tkst_pkg::NameW-1:0]    dn_name,
  output logic signed [tkst_pkg::ScoreW-1:0]   score,
  output logic        [tkst_pkg::NameW-1:0]    name,
  output logic                                 cmp
);

  // The new entry ranks above this cell when the cell is empty or holds a lower entry.
  assign cmp = !valid || (new_score > score) ||
               ((new_score == score) && (new_name > name));

  // On insert, cells below the insertion point shift down and the point takes
  // the new entry; on rotate, every cell takes its lower neighbor's entry and the bottom cell takes the top's.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_cmp) begin
        score <= up_score;
        name  <= up_name;
      end else if (cmp) begin
        score <= new_score;
        name  <= new_name;
      end
    end else if (ctl.rot) begin
      score <= dn_score;
      name  <= dn_name;
    end
  end

endmodule

>>> rtl/top_k_score_table_unit.sv
// Sorted table of the best DEPTH (score, name) entries, highest first.
// Ordering is by signed score, then by the packed name as an unsigned number.
// Command channel: an item is taken on a clock edge with start high and busy
// low. Operation 0 inserts, 1 dumps all entries, 2 looks up a score by name.
// Results appear on result_score, result_name, found and last for exactly one
// cycle, marked by strobe; the receiver has no way to hold them off.
// Insert and unused codes: the item passes through S_EXEC, which registers
// its one result; a new item is taken once the block is idle again.
// Dump and query: the entries live in a chain of cells that is rotated once
// around, one cell per cycle, and busy stays high until the rotation ends. A
// dump gives its entries in order, top first; a query gives its single result
// at the end of the scan. A new item is taken once busy falls again.
// Reset empties the table and clears busy and strobe; stored entry contents
// are not cleared, since only occupied cells are ever read.
module top_k_score_table_unit #(
  parameter int unsigned DEPTH      = tkst_pkg::DefaultDepth,
  parameter int unsigned NAME_CHARS = tkst_pkg::DefaultNameChars
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic        [1:0]                  operation,
  input  logic signed [tkst_pkg::ScoreW-1:0] score,
  input  logic        [tkst_pkg::NameW-1:0]  player_name,
  output logic                               strobe,
  output logic signed [tkst_pkg::ScoreW-1:0] result_score,
  output logic        [tkst_pkg::NameW-1:0]  result_name,
  output logic                               found,
  output logic                               last
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned StepW = $clog2(DEPTH);
  localparam logic [tkst_pkg::NameW-1:0] NameMask =
    (NAME_CHARS >= 8) ? {tkst_pkg::NameW{1'b1}}
                      : ((64'd1 << (8 * NAME_CHARS)) - 64'd1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(DEPTH);
  localparam logic [StepW-1:0] StepLast = StepW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t                              state;
  logic [1:0]                          op;
  logic signed [tkst_pkg::ScoreW-1:0]  item_score;
  logic        [tkst_pkg::NameW-1:0]   item_name;
  logic [CntW-1:0]                     count;
  logic [StepW-1:0]                    step;
  logic                                hit;
  logic signed [tkst_pkg::ScoreW-1:0]  hit_score;
  logic        [tkst_pkg::NameW-1:0]   hit_name;

  logic signed [tkst_pkg::ScoreW-1:0]  cell_score [DEPTH];
  logic        [tkst_pkg::NameW-1:0]   cell_name  [DEPTH];
  logic                                cell_cmp   [DEPTH];
  tkst_pkg::cell_ctl_t                 ctl;

  logic            full;
  logic            taken;
  logic            step_valid;
  logic            qmatch;
  logic [CntW-1:0] step_ext;

  // Insert is refused only when the table is full and the score is not above the lowest.
  assign full       = (count == CntFull);
  assign taken      = !full || (item_score > cell_score[DEPTH-1]);
  assign step_ext   = CntW'(step);
  assign step_valid = (step_ext < count);
  assign qmatch     = step_valid && (cell_name[0] == item_name);
  assign busy       = (state != S_IDLE);

  assign ctl.ins = (state == S_EXEC) && (op == tkst_pkg::OP_INSERT) && taken;
  assign ctl.rot = (state == S_SCAN);

  // The chain of cells; cell 0 holds the top entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [tkst_pkg::ScoreW-1:0] up_score;
    logic        [tkst_pkg::NameW-1:0]  up_name;
    logic                               prev_cmp;
    logic                               valid;

    if (i == 0) begin : g_top
      assign up_score = '0;
      assign up_name  = '0;
      assign prev_cmp = 1'b0;
    end else begin : g_rest
      assign up_score = cell_score[i-1];
      assign up_name  = cell_name[i-1];
      assign prev_cmp = cell_cmp[i-1];
    end

    assign valid = (CntW'(i) < count);

    tkst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (valid),
      .new_score (item_score),
      .new_name  (item_name),
      .prev_cmp  (prev_cmp),
      .up_score  (up_score),
      .up_name   (up_name),
      .dn_score  (cell_score[(i + 1) % DEPTH]),
      .dn_name   (cell_name[(i + 1) % DEPTH]),
      .score     (cell_score[i]),
      .name      (cell_name[i]),
      .cmp       (cell_cmp[i])
    );
  end

  // Item payload capture; the name is trimmed to its byte length here.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op         <= operation;
      item_score <= score;
      item_name  <= player_name & NameMask;
    end
  end

  // Sequencer, occupancy, query tracking and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      step   <= '0;
      hit    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            step <= '0;
            hit  <= 1'b0;
            if ((operation == tkst_pkg::OP_DUMP) || (operation == tkst_pkg::OP_QUERY)) begin
              state <= S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          strobe       <= 1'b1;
          result_score <= '0;
          result_name  <= '0;
          last         <= 1'b1;
          found        <= 1'b0;
          if (op == tkst_pkg::OP_INSERT) begin
            found <= taken;
            if (taken && !full) begin
              count <= count + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (op == tkst_pkg::OP_DUMP) begin
            if (step_valid) begin
              strobe       <= 1'b1;
              result_score <= cell_score[0];
              result_name  <= cell_name[0];
              found        <= 1'b1;
              last         <= (step_ext == count - 1'b1);
            end else if ((count == '0) && (step == '0)) begin
              strobe       <= 1'b1;
              result_score <= '0;
              result_name  <= '0;
              found        <= 1'b0;
              last         <= 1'b1;
            end
          end else begin
            if (qmatch && !hit) begin
              hit       <= 1'b1;
              hit_score <= cell_score[0];
              hit_name  <= cell_name[0];
            end
            if (step == StepLast) begin
              strobe <= 1'b1;
              last   <= 1'b1;
              if (hit) begin
                found        <= 1'b1;
                result_score <= hit_score;
                result_name  <= hit_name;
              end else if (qmatch) begin
                found        <= 1'b1;
                result_score <= cell_score[0];
                result_name  <= cell_name[0];
              end else begin
                found        <= 1'b0;
                result_score <= '0;
                result_name  <= '0;
              end
            end
          end
          if (step == StepLast) begin
            state <= S_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/tkst_checker.sv
module tkst_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [31:0] result_score,
  input logic [63:0] result_name,
  input logic        found,
  input logic        last
);

  // A taken item always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item taken but block not busy afterwards");

  // Every result comes from work that was under way in the cycle before.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result without preceding work");

  // Only the final result of an item may appear once the block is idle.
  assert property (@(posedge clk) disable iff (rst) (strobe && !busy) |-> last)
    else $error("non-final result while idle");

  // A dump entry that is not the final one always carries a stored entry.
  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |-> found)
    else $error("non-final result without an entry");

  // A result without an entry carries zero score and name.
  assert property (@(posedge clk) disable iff (rst)
                   (strobe && !found) |-> ((result_score == '0) && (result_name == '0)))
    else $error("empty result with nonzero payload");

endmodule

bind top_k_score_table_unit tkst_checker u_tkst_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .result_score (result_score),
  .result_name  (result_name),
  .found        (found),
  .last         (last)
);
